### hdl/hue_rotate_saturation_set_assert.svh
// Assertion macros for the hue rotate and saturation set block.
`ifndef HUE_ROTATE_SATURATION_SET_ASSERT_SVH
`define HUE_ROTATE_SATURATION_SET_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define HRS_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Implication that must hold in the clock cycle after the condition.
`define HRS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

### hdl/hrs_pkg.sv
// Package with shared types and constants for the hue rotate and saturation set block.
package hrs_pkg;
	localparam int unsigned HUE_SECTOR_W = 3;
	localparam int unsigned HUE_W        = 11;
	localparam logic [10:0] HUE_PERIOD   = 11'd1536;

	localparam logic [1:0] REG_COEF_DIAG  = 2'd0;
	localparam logic [1:0] REG_COEF_MINUS = 2'd1;
	localparam logic [1:0] REG_COEF_PLUS  = 2'd2;
	localparam logic [1:0] REG_SAT_LEVEL  = 2'd3;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;
endpackage

### hdl/hue_rotate_saturation_set.sv
// Hue rotate and saturation set: one 8-bit RGB pixel in and out per clock once the
// pipeline is full and while the output is not stalled. The stages are, in order,
// rotation, min/max, hue divider, saturation and output. The whole pipeline advances
// together and holds while the output is stalled. The output register frees the
// input side whenever the output stage is empty or being taken.
module hue_rotate_saturation_set import hrs_pkg::*; #(
	parameter int unsigned COEF_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // blue_in [23:16], green_in [15:8], red_in [7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // blue_out [23:16], green_out [15:8], red_out [7:0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	`include "hue_rotate_saturation_set_assert.svh"

	localparam int unsigned LAT = 12;
	localparam int unsigned ACC_W = 8 + 16 + 3;

	logic signed [15:0] coef_diag_q, coef_minus_q, coef_plus_q;
	logic [7:0]         sat_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_diag_q  <= 16'sd16384;
			coef_minus_q <= '0;
			coef_plus_q  <= '0;
			sat_level_q  <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_DIAG:  coef_diag_q  <= cfg_data;
				REG_COEF_MINUS: coef_minus_q <= cfg_data;
				REG_COEF_PLUS:  coef_plus_q  <= cfg_data;
				REG_SAT_LEVEL:  sat_level_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Whole pipe advances when the output slot is free or being drained.
	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end

	// s1: the nine products.
	logic [7:0] ri, gi, bi;
	assign ri = s_axis_tdata[7:0];
	assign gi = s_axis_tdata[15:8];
	assign bi = s_axis_tdata[23:16];
	logic signed [24:0] p_s1 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= $signed({1'b0, ri}) * coef_diag_q;
			p_s1[1] <= $signed({1'b0, gi}) * coef_minus_q;
			p_s1[2] <= $signed({1'b0, bi}) * coef_plus_q;
			p_s1[3] <= $signed({1'b0, ri}) * coef_plus_q;
			p_s1[4] <= $signed({1'b0, gi}) * coef_diag_q;
			p_s1[5] <= $signed({1'b0, bi}) * coef_minus_q;
			p_s1[6] <= $signed({1'b0, ri}) * coef_minus_q;
			p_s1[7] <= $signed({1'b0, gi}) * coef_plus_q;
			p_s1[8] <= $signed({1'b0, bi}) * coef_diag_q;
		end
	end

	// s2: sum, round half up, clip.
	function automatic logic [7:0] rnd_clip(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] q;
		t = acc + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
		q = t >>> COEF_FRAC_BITS;
		if (t < 0) return 8'd0;
		else if (q > 255) return 8'd255;
		else return q[7:0];
	endfunction

	rgb_t rot_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s2.r <= rnd_clip(ACC_W'(p_s1[0]) + ACC_W'(p_s1[1]) + ACC_W'(p_s1[2]));
			rot_s2.g <= rnd_clip(ACC_W'(p_s1[3]) + ACC_W'(p_s1[4]) + ACC_W'(p_s1[5]));
			rot_s2.b <= rnd_clip(ACC_W'(p_s1[6]) + ACC_W'(p_s1[7]) + ACC_W'(p_s1[8]));
		end
	end

	// s3: max, min, dominant channel, step operands.
	logic [7:0] v_c, mn_c, a_c, b_c;
	logic [1:0] dom_c;
	always_comb begin
		v_c = rot_s2.r;
		if (rot_s2.g > v_c) v_c = rot_s2.g;
		if (rot_s2.b > v_c) v_c = rot_s2.b;
		mn_c = rot_s2.r;
		if (rot_s2.g < mn_c) mn_c = rot_s2.g;
		if (rot_s2.b < mn_c) mn_c = rot_s2.b;
		if (v_c == rot_s2.r) begin
			dom_c = 2'd0; a_c = rot_s2.g; b_c = rot_s2.b;
		end else if (v_c == rot_s2.g) begin
			dom_c = 2'd1; a_c = rot_s2.b; b_c = rot_s2.r;
		end else begin
			dom_c = 2'd2; a_c = rot_s2.r; b_c = rot_s2.g;
		end
	end

	logic [7:0] v_s3, d_s3, num_s3;
	logic [1:0] dom_s3;
	logic       neg_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			v_s3   <= v_c;
			d_s3   <= v_c - mn_c;
			dom_s3 <= dom_c;
			neg_s3 <= a_c < b_c;
			num_s3 <= (a_c < b_c) ? b_c - a_c : a_c - b_c;
		end
	end

	// s4..s8: hue divider; tag carries v, dom, sign, grey flag.
	localparam int unsigned TAG_W = 12;
	logic [9:0]       quo_s8;
	logic [TAG_W-1:0] tag_s8;
	hrs_hue_div #(.TAG_W(TAG_W)) u_div (
		.clk    (clk),
		.en     (en),
		.num    (num_s3),
		.den    ((d_s3 == 8'd0) ? 8'd1 : d_s3),
		.tag_in ({d_s3 == 8'd0, neg_s3, dom_s3, v_s3}),
		.quo    (quo_s8),
		.tag_out(tag_s8)
	);

	// s9: hue wrap, chroma product.
	logic signed [12:0] h_c;
	logic [HUE_W-1:0]   h_w;
	always_comb begin
		h_c = $signed({2'b00, tag_s8[9:8], 9'd0})
			+ (tag_s8[10] ? -$signed({3'b000, quo_s8}) : $signed({3'b000, quo_s8}));
		if (tag_s8[11]) h_w = '0;
		else if (h_c < 0) h_w = HUE_W'(h_c + 13'sd1536);
		else if (h_c >= 13'sd1536) h_w = HUE_W'(h_c - 13'sd1536);
		else h_w = h_c[HUE_W-1:0];
	end

	logic [HUE_W-1:0] h_s9;
	logic [7:0]       v_s9;
	logic [15:0]      vs_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s9  <= h_w;
			v_s9  <= tag_s8[7:0];
			vs_s9 <= tag_s8[7:0] * sat_level_q;
		end
	end

	// s10: c = (vs+127)/255 via reciprocal: (t + (t>>8) + 1) >> 8 for t < 2^16 - 1.
	logic [16:0] t_c;
	logic [16:0] cq_c;
	always_comb begin
		t_c  = 17'(vs_s9) + 17'd127;
		cq_c = (t_c + (t_c >> 8) + 17'd1) >> 8;
	end

	logic [HUE_W-1:0] h_s10;
	logic [7:0]       v_s10, c_s10;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s10 <= h_s9;
			v_s10 <= v_s9;
			c_s10 <= cq_c[7:0];
		end
	end

	// s11: x product.
	logic [8:0] fr_c;
	assign fr_c = h_s10[8] ? 9'd256 - {1'b0, h_s10[7:0]} : {1'b0, h_s10[7:0]};

	logic [HUE_SECTOR_W-1:0] sec_s11;
	logic [7:0]              v_s11, m_s11;
	logic [16:0]             xp_s11;
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s11 <= h_s10[10:8];
			v_s11   <= v_s10;
			m_s11   <= v_s10 - c_s10;
			xp_s11  <= c_s10 * fr_c;
		end
	end

	// s12: sector table and output register.
	logic [8:0] x_c;
	logic [7:0] xc_c;
	rgb_t       o_c;
	always_comb begin
		x_c  = 9'((xp_s11 + 17'd128) >> 8) + {1'b0, m_s11};
		xc_c = x_c[8] ? 8'd255 : x_c[7:0];
		case (sec_s11)
			3'd0:    o_c = '{r: v_s11, g: xc_c,  b: m_s11};
			3'd1:    o_c = '{r: xc_c,  g: v_s11, b: m_s11};
			3'd2:    o_c = '{r: m_s11, g: v_s11, b: xc_c};
			3'd3:    o_c = '{r: m_s11, g: xc_c,  b: v_s11};
			3'd4:    o_c = '{r: xc_c,  g: m_s11, b: v_s11};
			default: o_c = '{r: v_s11, g: m_s11, b: xc_c};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= {o_c.b, o_c.g, o_c.r};
	end

	`HRS_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata) && m_axis_tvalid, "stalled output changed")
	`HRS_ASSERT_IMPL(a_ready_free, clk, arst_n, !m_axis_tvalid, s_axis_tready,
		"input blocked with empty output")
	`HRS_ASSERT_IMPL(a_hue_range, clk, arst_n, vld_q[8], h_s9 < HUE_PERIOD,
		"hue out of range")
	`HRS_ASSERT_IMPL(a_chroma, clk, arst_n, vld_q[9], c_s10 <= v_s10,
		"chroma above value")
endmodule

### hdl/hrs_hue_div.sv
// Pipelined restoring divider for the hue step: round(num*256/d), one quotient bit a step.
module hrs_hue_div import hrs_pkg::*; #(
	parameter int unsigned TAG_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [7:0]       num,
	input  logic [7:0]       den,
	input  logic [TAG_W-1:0] tag_in,
	output logic [9:0]       quo,
	output logic [TAG_W-1:0] tag_out
);
	// Dividend is num*256 + den/2 (< 2^17); quotient fits in 9 bits when num <= den.
	// 17 steps, registered after every fourth step and at the output.
	localparam int unsigned NST = 17;
	logic [16:0]      dvd_s [NST+1];
	logic [8:0]       rem_s [NST+1];
	logic [16:0]      q_s   [NST+1];
	logic [7:0]       den_s [NST+1];
	logic [TAG_W-1:0] tag_s [NST+1];

	always_comb begin
		dvd_s[0] = {1'b0, num, 8'd0} + {10'd0, den[7:1]};
		rem_s[0] = '0;
		q_s[0]   = '0;
		den_s[0] = den;
		tag_s[0] = tag_in;
	end

	for (genvar i = 0; i < NST; i++) begin : g_st
		logic [9:0] trial;
		always_comb trial = {rem_s[i], dvd_s[i][16-i]} - {2'd0, den_s[i]};
		// Register every fourth step to keep each stage short.
		if ((i % 4) == 3) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= trial[9] ? {rem_s[i][7:0], dvd_s[i][16-i]} : trial[8:0];
					q_s[i+1]   <= {q_s[i][15:0], ~trial[9]};
					dvd_s[i+1] <= dvd_s[i];
					den_s[i+1] <= den_s[i];
					tag_s[i+1] <= tag_s[i];
				end
			end
		end else begin : g_cmb
			always_comb begin
				rem_s[i+1] = trial[9] ? {rem_s[i][7:0], dvd_s[i][16-i]} : trial[8:0];
				q_s[i+1]   = {q_s[i][15:0], ~trial[9]};
				dvd_s[i+1] = dvd_s[i];
				den_s[i+1] = den_s[i];
				tag_s[i+1] = tag_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo     <= q_s[NST][9:0];
			tag_out <= tag_s[NST];
		end
	end
endmodule
